@@ hdl/bced_pkg.sv @@
`default_nettype none

package bced_pkg;

   // Event codes carried on the result channel.
   typedef enum logic [1:0] {
      EV_PRESSED  = 2'd0,
      EV_RELEASED = 2'd1,
      EV_DOUBLE   = 2'd2,
      EV_LONG     = 2'd3
   } event_code_type;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_DEBOUNCE  = 2'd0,
      CSR_HOLD_TIME = 2'd1,
      CSR_CLICK_GAP = 2'd2
   } csr_index_type;

   localparam logic [15:0] DEBOUNCE_RESET  = 16'd50;
   localparam logic [15:0] HOLD_TIME_RESET = 16'd500;
   localparam logic [15:0] CLICK_GAP_RESET = 16'd300;

   // Number of short clicks in the window that makes a double click.
   localparam logic [1:0] DOUBLE_TALLY = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // One classified sample: one or two events for one button.
   typedef struct packed {
      logic [1:0]     button;
      logic           two;
      event_code_type code0;
      event_code_type code1;
   } run_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

@@ hdl/bced_front.sv @@
`default_nettype none

module bced_front #(
   parameter int NUM_BUTTONS = 3
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_write_enable,
   input  wire logic [1:0]      csr_index,
   input  wire logic [15:0]     csr_write_data,
   input  wire logic            accept,
   input  wire logic [1:0]      button_index,
   input  wire logic            is_down,
   input  wire logic [31:0]     now_ms,
   output      logic            push,
   output      bced_pkg::run_type push_run
);
   import bced_pkg::*;

   localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam logic [5:0] NUM_B = 6'(NUM_BUTTONS);

   logic [15:0] debounce_ff, hold_time_ff, click_gap_ff;

   logic        raw_prev_ff     [NUM_BUTTONS];
   logic        stable_ff       [NUM_BUTTONS];
   logic [31:0] change_stamp_ff [NUM_BUTTONS];
   logic [31:0] press_stamp_ff  [NUM_BUTTONS];
   logic        long_fired_ff   [NUM_BUTTONS];
   logic [31:0] click_stamp_ff  [NUM_BUTTONS];
   logic [1:0]  click_tally_ff  [NUM_BUTTONS];

   logic [IDX_W-1:0] sel;
   logic        in_range;
   logic        changed, settled, trans, press, release_ev, dbl, long_ev;
   logic        in_window, take;
   logic [31:0] since_change, since_press, since_click;
   logic [1:0]  tally_inc, tally_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= DEBOUNCE_RESET;
         hold_time_ff <= HOLD_TIME_RESET;
         click_gap_ff <= CLICK_GAP_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEBOUNCE:  debounce_ff  <= csr_write_data;
            CSR_HOLD_TIME: hold_time_ff <= csr_write_data;
            CSR_CLICK_GAP: click_gap_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign sel      = IDX_W'(button_index);
   assign in_range = {4'b0, button_index} < NUM_B;
   assign take     = accept && in_range;

   assign since_change = now_ms - change_stamp_ff[sel];
   assign since_press  = now_ms - press_stamp_ff[sel];
   assign since_click  = now_ms - click_stamp_ff[sel];

   // A fresh change restarts the debounce time, so it cannot settle now.
   assign changed    = is_down != raw_prev_ff[sel];
   assign settled    = !changed && (since_change > {16'b0, debounce_ff});
   assign trans      = settled && (is_down != stable_ff[sel]);
   assign press      = trans && is_down;
   assign release_ev = trans && !is_down;
   assign in_window  = since_click < {16'b0, click_gap_ff};
   assign tally_inc  = click_tally_ff[sel] + 2'd1;
   assign dbl        = release_ev && !long_fired_ff[sel] && in_window &&
                       (tally_inc >= DOUBLE_TALLY);
   assign long_ev    = settled && !trans && stable_ff[sel] && !long_fired_ff[sel] &&
                       (since_press > {16'b0, hold_time_ff});
   assign tally_in   = !in_window ? 2'd1 : (tally_inc >= DOUBLE_TALLY) ? 2'd0 : tally_inc;

   always_comb begin
      push_run.button = button_index;
      push_run.two    = dbl;
      push_run.code0  = press ? EV_PRESSED : dbl ? EV_DOUBLE :
                        release_ev ? EV_RELEASED : EV_LONG;
      push_run.code1  = EV_RELEASED;
   end

   assign push = take && (press || release_ev || long_ev);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            raw_prev_ff[i]     <= 1'b0;
            stable_ff[i]       <= 1'b0;
            change_stamp_ff[i] <= '0;
            press_stamp_ff[i]  <= '0;
            long_fired_ff[i]   <= 1'b0;
            click_stamp_ff[i]  <= '0;
            click_tally_ff[i]  <= '0;
         end
      end else if (take) begin
         raw_prev_ff[sel] <= is_down;
         if (changed) begin
            change_stamp_ff[sel] <= now_ms;
         end
         if (trans) begin
            stable_ff[sel] <= is_down;
         end
         if (press) begin
            press_stamp_ff[sel] <= now_ms;
            long_fired_ff[sel]  <= 1'b0;
         end
         if (long_ev) begin
            long_fired_ff[sel] <= 1'b1;
         end
         // A release that ends a long press does not count as a click.
         if (release_ev && !long_fired_ff[sel]) begin
            click_stamp_ff[sel] <= now_ms;
            click_tally_ff[sel] <= tally_in;
         end
      end
   end

endmodule

`default_nettype wire

@@ hdl/bced_queue.sv @@
`default_nettype none

module bced_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire bced_pkg::run_type      push_run,
   input  wire logic                   pop,
   output      bced_pkg::run_type      head_run,
   output      bced_pkg::queue_status_type status
);
   import bced_pkg::*;

   run_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign status.full  = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_run     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_run;
      end
   end

endmodule

`default_nettype wire

@@ hdl/bced_back.sv @@
`default_nettype none

module bced_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire bced_pkg::run_type          head_run,
   input  wire bced_pkg::queue_status_type status,
   output      logic                       pop,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      logic [1:0]                 rsp_event_button,
   output      logic [1:0]                 rsp_event_code,
   output      logic                       rsp_last_of_run
);
   import bced_pkg::*;

   logic           valid_ff, valid_in;
   logic           second_ff, second_in;
   logic [1:0]     button_ff;
   event_code_type code_ff;
   logic           last_ff;
   logic           load, last_now;

   // The output register is refilled whenever it is empty or being taken.
   assign load     = !status.empty && (!valid_ff || !rsp_stall);
   assign last_now = !head_run.two || second_ff;
   assign pop      = load && last_now;

   always_comb begin
      valid_in  = load ? 1'b1 : (valid_ff && rsp_stall);
      second_in = load ? !last_now : second_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         button_ff <= head_run.button;
         code_ff   <= second_ff ? head_run.code1 : head_run.code0;
         last_ff   <= last_now;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_event_button = button_ff;
   assign rsp_event_code   = code_ff;
   assign rsp_last_of_run  = last_ff;

endmodule

`default_nettype wire

@@ hdl/button_click_event_detector.sv @@
// Button click event detector for several buttons.
// The req channel carries one raw sample per transfer: the button index, the sampled
// level (1 = pressed) and a millisecond timestamp that wraps modulo 2^32. The rsp
// channel carries events (pressed, released, double click, long press), each with
// its button and a flag that marks the last event caused by one sample; a sample
// causes zero, one or two events.
// The csr port writes the debounce, long-press and double-click times (16 bits,
// milliseconds) at any edge with csr_write_enable high; write only while idle.
// Samples are taken one per cycle while req_stall is low. Each event passes through
// the queue into the rsp register; the second event of a sample is loaded as the first is taken.
// A four-entry queue sits between the classifying front end and the output stage, so
// req_stall rises only when that queue is full, which happens when the receiver
// holds rsp_stall or when two-event runs arrive faster than they drain.
// Samples for a button index at or beyond NUM_BUTTONS are taken and ignored.
// Synchronous reset puts every button in the released state with no clicks counted,
// restores the register defaults (50, 500, 300) and empties the queue and output.
`default_nettype none

module button_click_event_detector #(
   parameter int NUM_BUTTONS = 3
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_button_index,
   input  wire logic        req_is_down,
   input  wire logic [31:0] req_now_ms,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [1:0]  rsp_event_button,
   output      logic [1:0]  rsp_event_code,
   output      logic        rsp_last_of_run
);
   import bced_pkg::*;

   logic             accept;
   logic             push, pop;
   run_type          push_run, head_run;
   queue_status_type status;

   // The front end takes a sample whenever the queue has room.
   assign req_stall = status.full;
   assign accept    = req_valid && !req_stall;

   bced_front #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .button_index     (req_button_index),
      .is_down          (req_is_down),
      .now_ms           (req_now_ms),
      .push             (push),
      .push_run         (push_run)
   );

   bced_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .pop      (pop),
      .head_run (head_run),
      .status   (status)
   );

   bced_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_run         (head_run),
      .status           (status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_button (rsp_event_button),
      .rsp_event_code   (rsp_event_code),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   // The only two-event run is a double click followed by its release.
   a_first_is_double: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> (rsp_event_code == EV_DOUBLE))
      else $error("first event of a two-event run is not a double click");

   // Once the first event of a run is taken, the release follows at once.
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_of_run) |=>
      (rsp_valid && rsp_last_of_run && rsp_event_code == EV_RELEASED))
      else $error("second event of a run did not follow");

   // A full queue must hold off the request side.
   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      (push && status.full) |-> 1'b0)
      else $error("event run pushed into a full queue");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the button click event detector.
module testbench;
   import bced_pkg::*;

   localparam int NUM_BUTTONS   = 3;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_AFTER    = 600;
   localparam int HOLD_CYCLES   = 300;
   localparam int MAX_REPORTS   = 10;

   // The register port is two bits wide, but only three registers exist.
   // Writes to the spare index must be dropped by the block.
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  button;
      logic        down;
      logic [31:0] stamp;
   } button_sample_type;

   typedef struct packed {
      logic [1:0]     button;
      event_code_type code;
      logic           last;
   } click_event_type;

   // Clock, reset and the block's ports. Every input starts at a known value.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_button_index = '0;
   logic        req_is_down = 1'b0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_event_button;
   logic [1:0]  rsp_event_code;
   logic        rsp_last_of_run;

   // Samples waiting to be offered, and events the block still owes us.
   button_sample_type sample_queue[$];
   click_event_type   pending_events[$];
   button_sample_type driven_sample;

   // Our own copy of the timing registers.
   logic [15:0] debounce_time;
   logic [15:0] hold_time;
   logic [15:0] click_gap_time;

   // Our own copy of the per-button debounce and click state.
   logic        raw_seen   [NUM_BUTTONS];
   logic        held_level [NUM_BUTTONS];
   logic [31:0] edge_ms    [NUM_BUTTONS];
   logic [31:0] press_ms   [NUM_BUTTONS];
   logic        long_sent  [NUM_BUTTONS];
   logic [31:0] click_ms   [NUM_BUTTONS];
   logic [1:0]  clicks     [NUM_BUTTONS];

   logic [31:0] clock_ms;
   int          samples_made;
   int          samples_taken;
   int          mismatches;
   int          send_gap;
   int          recv_gap;
   int          hold_left;
   bit          hold_done;
   bit          calm;
   int          cycles_run;

   button_click_event_detector #(
      .NUM_BUTTONS(NUM_BUTTONS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_button_index(req_button_index),
      .req_is_down(req_is_down),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_event_button(rsp_event_button),
      .rsp_event_code(rsp_event_code),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic click_event_type make_event(input logic [1:0] button,
                                                  input event_code_type code);
      click_event_type ev;
      ev.button = button;
      ev.code   = code;
      ev.last   = 1'b0;
      return ev;
   endfunction

   // Works out the events that one sample causes and queues them in order.
   // All time differences are 32-bit, so they wrap the way the timestamp does.
   task automatic classify_sample(input button_sample_type s);
      click_event_type run[$];
      logic [31:0]  since_edge;
      logic [31:0]  since_click;
      logic [31:0]  since_press;
      int unsigned  b;
      if ({30'b0, s.button} >= NUM_BUTTONS) begin
         return;
      end
      b = {30'b0, s.button};
      if (s.down != raw_seen[b]) begin
         edge_ms[b] = s.stamp;
      end
      since_edge = s.stamp - edge_ms[b];
      // A level counts only after it has held strictly longer than the debounce time.
      if (since_edge > {16'b0, debounce_time}) begin
         if (s.down != held_level[b]) begin
            held_level[b] = s.down;
            if (s.down) begin
               press_ms[b]  = s.stamp;
               long_sent[b] = 1'b0;
               run.push_back(make_event(s.button, EV_PRESSED));
            end else begin
               // A release that ends a long press neither counts as a click nor
               // moves the click window.
               if (!long_sent[b]) begin
                  since_click = s.stamp - click_ms[b];
                  if (since_click < {16'b0, click_gap_time}) begin
                     clicks[b] = clicks[b] + 2'd1;
                     if (clicks[b] >= DOUBLE_TALLY) begin
                        run.push_back(make_event(s.button, EV_DOUBLE));
                        clicks[b] = '0;
                     end
                  end else begin
                     clicks[b] = 2'd1;
                  end
                  click_ms[b] = s.stamp;
               end
               run.push_back(make_event(s.button, EV_RELEASED));
            end
         end
         since_press = s.stamp - press_ms[b];
         if (held_level[b] && !long_sent[b] && run.size() < 2 &&
             since_press > {16'b0, hold_time}) begin
            long_sent[b] = 1'b1;
            run.push_back(make_event(s.button, EV_LONG));
         end
      end
      raw_seen[b] = s.down;
      foreach (run[i]) begin
         run[i].last = (i == run.size() - 1);
         pending_events.push_back(run[i]);
      end
   endtask

   task automatic push_sample(input logic [1:0] button, input logic down,
                              input logic [31:0] stamp);
      button_sample_type s;
      s.button = button;
      s.down   = down;
      s.stamp  = stamp;
      sample_queue.push_back(s);
      samples_made++;
   endtask

   // Moves the time line on by a gap and queues a sample there. Now and then a
   // stray sample for any button, the spare index included, slips in first.
   task automatic sample_after(input logic [1:0] button, input logic down,
                               input logic [31:0] gap);
      if ($urandom_range(0, 7) == 0) begin
         clock_ms += $urandom_range(0, 3);
         push_sample(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), clock_ms);
      end
      clock_ms += gap;
      push_sample(button, down, clock_ms);
   endtask

   // Gaps for the broken stretches: mostly on the scale of the timing
   // registers, rarely a jump anywhere on the 32-bit time line.
   function automatic logic [31:0] wild_gap();
      case ($urandom_range(0, 9))
         6, 7:    return $urandom_range(0, hold_time + 2);
         8:       return $urandom_range(0, click_gap_time + 2);
         9:       return ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 65535);
         default: return $urandom_range(0, debounce_time + 2);
      endcase
   endfunction

   // One user gesture on one button: one to three clicks, each with optional
   // contact bounce, a press held near the debounce or long-press limit and a
   // release. Clicks follow closely, so double clicks come up often. One
   // gesture in five is plain noise instead.
   task automatic queue_gesture();
      logic [1:0] b;
      b = 2'($urandom_range(0, NUM_BUTTONS - 1));
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(2, 6)) begin
            sample_after(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), wild_gap());
         end
         return;
      end
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               sample_after(b, 1'b1, $urandom_range(0, debounce_time));
               sample_after(b, 1'b0, $urandom_range(0, debounce_time));
            end
         end
         sample_after(b, 1'b1, $urandom_range(0, 3));
         sample_after(b, 1'b1, debounce_time + $urandom_range(0, 2));
         case ($urandom_range(0, 2))
            0: sample_after(b, 1'b1, hold_time + $urandom_range(0, 2));
            1: sample_after(b, 1'b1, $urandom_range(0, debounce_time));
            default: ;
         endcase
         sample_after(b, 1'b0, $urandom_range(0, 3));
         sample_after(b, 1'b0, debounce_time + $urandom_range(0, 2));
         if ($urandom_range(0, 3) == 0) begin
            sample_after(b, 1'b0, $urandom_range(0, click_gap_time + 2));
         end
      end
   endtask

   task automatic queue_phase(input int count);
      int target;
      target = samples_made + count;
      while (samples_made < target) begin
         queue_gesture();
      end
   endtask

   // Waits until every sample has been taken and every event has come back,
   // then gives the block time to finish samples that cause no event.
   task automatic wait_until_drained();
      while (sample_queue.size() != 0 || req_valid || pending_events.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_DEBOUNCE:  debounce_time  = value;
         CSR_HOLD_TIME: hold_time      = value;
         CSR_CLICK_GAP: click_gap_time = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [15:0] debounce, input logic [15:0] hold_limit,
                            input logic [15:0] click_gap);
      wait_until_drained();
      write_csr(CSR_DEBOUNCE, debounce);
      write_csr(CSR_HOLD_TIME, hold_limit);
      write_csr(CSR_CLICK_GAP, click_gap);
   endtask

   // Sender. A new sample is put on the bus only when the previous one has
   // transferred or nothing was offered, so a stalled sample stays put. The
   // prediction is made at the edge where the transfer happens.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            classify_sample(driven_sample);
            samples_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
               send_gap = $urandom_range(0, 2);
               req_valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
               driven_sample = sample_queue.pop_front();
               req_valid        <= 1'b1;
               req_button_index <= driven_sample.button;
               req_is_down      <= driven_sample.down;
               req_now_ms       <= driven_sample.stamp;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver. Short random stalls, plus one long hold-off once enough samples
   // have gone in, so that the event queue fills and the block stalls its
   // input while the sender keeps offering.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && samples_taken >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         recv_gap = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Checker. Every event that transfers is matched against the oldest
   // prediction; all three fields must agree.
   always @(posedge clock) begin
      click_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected event: button %0d code %0d last %0b",
                        rsp_event_button, rsp_event_code, rsp_last_of_run);
            end
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_button !== want.button || rsp_event_code !== want.code ||
                rsp_last_of_run !== want.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("event mismatch: expected button %0d code %0d last %0b,",
                           want.button, want.code, want.last,
                           " got button %0d code %0d last %0b",
                           rsp_event_button, rsp_event_code, rsp_last_of_run);
               end
            end
         end
      end
   end

   // Watchdog for a block that hangs or loses events.
   initial begin
      for (cycles_run = 0; cycles_run < CYCLE_LIMIT; cycles_run++) begin
         @(posedge clock);
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      debounce_time  = DEBOUNCE_RESET;
      hold_time      = HOLD_TIME_RESET;
      click_gap_time = CLICK_GAP_RESET;
      foreach (raw_seen[i]) begin
         raw_seen[i]   = 1'b0;
         held_level[i] = 1'b0;
         edge_ms[i]    = '0;
         press_ms[i]   = '0;
         long_sent[i]  = 1'b0;
         click_ms[i]   = '0;
         clicks[i]     = '0;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset timing of 50, 500 and 300 ms.
      // Button 0: a press held past the long-press time, then released, which
      // gives only a release.
      push_sample(2'd0, 1'b1, 32'd0);
      push_sample(2'd0, 1'b1, 32'd51);
      push_sample(2'd0, 1'b1, 32'd552);
      push_sample(2'd0, 1'b0, 32'd600);
      push_sample(2'd0, 1'b0, 32'd651);
      // Button 1: two short clicks inside the window make a double click,
      // which comes out just ahead of the second release.
      push_sample(2'd1, 1'b1, 32'd1000);
      push_sample(2'd1, 1'b1, 32'd1051);
      push_sample(2'd1, 1'b0, 32'd1060);
      push_sample(2'd1, 1'b0, 32'd1111);
      push_sample(2'd1, 1'b1, 32'd1120);
      push_sample(2'd1, 1'b1, 32'd1171);
      push_sample(2'd1, 1'b0, 32'd1180);
      push_sample(2'd1, 1'b0, 32'd1231);
      // Button 2: the first click after reset lands within the window of time
      // zero and so already counts as a click.
      push_sample(2'd2, 1'b1, 32'd1);
      push_sample(2'd2, 1'b1, 32'd52);
      push_sample(2'd2, 1'b0, 32'd60);
      push_sample(2'd2, 1'b0, 32'd111);
      // The spare button index is taken and ignored, at both timestamp extremes.
      push_sample(2'd3, 1'b1, 32'hFFFF_FFFF);
      push_sample(2'd3, 1'b0, 32'h0000_0000);
      // A press whose debounce interval spans the wrap of the timestamp.
      push_sample(2'd2, 1'b1, 32'hFFFF_FFF0);
      push_sample(2'd2, 1'b1, 32'h0000_0030);
      // A release that holds exactly the debounce time is not yet accepted;
      // one millisecond more is.
      push_sample(2'd2, 1'b0, 32'd100);
      push_sample(2'd2, 1'b0, 32'd150);
      push_sample(2'd2, 1'b0, 32'd151);
      wait_until_drained();

      clock_ms = 32'd2000;
      queue_phase(320);

      // Everything at zero: any later sample at the same level is accepted and
      // no release can make a double click.
      configure(16'd0, 16'd0, 16'd0);
      write_csr(CSR_UNUSED, 16'($urandom_range(0, 65535)));
      queue_phase(200);

      configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_phase(200);

      configure(16'd3, 16'd20, 16'd15);
      queue_phase(300);

      for (int i = 0; i < 3; i++) begin
         if (i == 2) begin
            configure(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)));
         end else begin
            configure(16'($urandom_range(0, 255)), 16'($urandom_range(0, 3000)),
                      16'($urandom_range(0, 1500)));
         end
         // Start somewhere else on the time line, the first time close to the wrap.
         clock_ms = (i == 0) ? 32'hFFFF_F000 : $urandom();
         queue_phase(200);
      end

      // Closing stretch at full rate on both sides.
      configure(16'd50, 16'd500, 16'd300);
      calm = 1'b1;
      queue_phase(250);

      wait_until_drained();
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
